// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the memory load governor checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a synchronous reset that disables the check.
`define MLT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define MLT_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `MLT_ASSERT(label, clk, rst, !(cond), msg)

`endif

// File: src/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Types and constants shared by the memory load governor modules.
// ----------------------------------------------------------------------------
package mlt_pkg;

   // Payload widths.
   localparam int CMD_W   = 2;
   localparam int CPU_W   = 3;
   localparam int WORD_W  = 32;
   localparam int RATE_W  = 64;
   localparam int LOAD_W  = 7;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CPU_MAX = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CPU_CUR = 2'd2;

   // Configuration space: two 32-bit registers at byte offsets 0 and 4.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_NORMAL_LOAD  = 1'b0;
   localparam logic REG_BOOSTED_LOAD = 1'b1;
   localparam logic [LOAD_W-1:0] NORMAL_LOAD_RESET  = 7'd15;
   localparam logic [LOAD_W-1:0] BOOSTED_LOAD_RESET = 7'd5;

   // Sample count scaling.
   localparam logic [WORD_W-1:0] SHIFT_LIMIT = 32'h0100_0000;
   localparam int COUNT_SHIFT = 7;

   // Shared divider geometry.
   localparam int DVD_W     = 64;
   localparam int DSR_W     = 32;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   // Write strobes toward the CPU frequency table.
   typedef struct packed {
      logic wr_max;
      logic wr_cur;
   } tbl_ctl_type;

endpackage

// File: src/mlt_if.sv
// ----------------------------------------------------------------------------
// mlt_req_if / mlt_rsp_if
// Valid/ready channels for governor requests and results.
// ----------------------------------------------------------------------------
interface mlt_req_if;
   logic                          valid;
   logic                          ready;
   logic [mlt_pkg::CMD_W-1:0]     command;
   logic [mlt_pkg::CPU_W-1:0]     cpu_index;
   logic [mlt_pkg::WORD_W-1:0]    cpu_khz;
   logic [mlt_pkg::WORD_W-1:0]    busy_count;
   logic [mlt_pkg::WORD_W-1:0]    window_total;
   logic [mlt_pkg::WORD_W-1:0]    memory_rate_hz;
   logic                          polling_stopped;
   logic [mlt_pkg::WORD_W-1:0]    suspend_rate_hz;

   modport source (output valid, command, cpu_index, cpu_khz, busy_count, window_total,
                   memory_rate_hz, polling_stopped, suspend_rate_hz, input ready);
   modport sink   (input valid, command, cpu_index, cpu_khz, busy_count, window_total,
                   memory_rate_hz, polling_stopped, suspend_rate_hz, output ready);
endinterface

interface mlt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mlt_pkg::RATE_W-1:0]    requested_rate;
   logic                          rate_valid;
   logic                          boost_active;
   logic                          boost_changed;

   modport source (output valid, requested_rate, rate_valid, boost_active, boost_changed,
                   input ready);
   modport sink   (input valid, requested_rate, rate_valid, boost_active, boost_changed,
                   output ready);
endinterface

// File: src/mlt_divider.sv
// ----------------------------------------------------------------------------
// mlt_divider
// Restoring divider, 64-bit dividend by 32-bit nonzero divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mlt_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mlt_pkg::DVD_W-1:0]   dividend,
   input  logic [mlt_pkg::DSR_W-1:0]   divisor,
   output logic                        done,
   output logic [mlt_pkg::DVD_W-1:0]   quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [mlt_pkg::DIV_CNT_W-1:0]     count_ff, count_in;
   logic [mlt_pkg::DVD_W-1:0]         dvd_ff, dvd_in;
   logic [mlt_pkg::DSR_W-1:0]         rem_ff, rem_in;
   logic [mlt_pkg::DSR_W-1:0]         dsr_ff, dsr_in;
   logic [mlt_pkg::DSR_W:0]           partial;
   logic [mlt_pkg::DSR_W:0]           diff;
   logic                              fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign partial = {rem_ff, dvd_ff[mlt_pkg::DVD_W-1]};
   assign diff    = partial - {1'b0, dsr_ff};
   assign fits    = partial >= {1'b0, dsr_ff};

   // The dividend register fills with quotient bits from the bottom.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[mlt_pkg::DVD_W-2:0], fits};
         rem_in   = fits ? diff[mlt_pkg::DSR_W-1:0] : partial[mlt_pkg::DSR_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == mlt_pkg::DIV_CNT_W'(mlt_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// File: src/mlt_cpu_table.sv
// ----------------------------------------------------------------------------
// mlt_cpu_table
// Per-CPU maximum and current frequency memories with one boost bit per
// CPU and the OR of those bits.
// ----------------------------------------------------------------------------
module mlt_cpu_table #(
   parameter int NUM_CPUS = 8,
   parameter int IDX_W    = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mlt_pkg::tbl_ctl_type          ctl,
   input  logic [IDX_W-1:0]              idx,
   input  logic [mlt_pkg::WORD_W-1:0]    wr_data,
   output logic [mlt_pkg::WORD_W-1:0]    max_q,
   output logic                          boost_any
);

   logic [mlt_pkg::WORD_W-1:0] max_mem [NUM_CPUS];
   logic [mlt_pkg::WORD_W-1:0] cur_mem [NUM_CPUS];
   logic [mlt_pkg::WORD_W-1:0] rd_max_ff;
   logic [mlt_pkg::WORD_W-1:0] rd_cur_ff;
   logic [mlt_pkg::WORD_W-1:0] cur_q;
   logic                       rd_max_vld_ff, rd_max_vld_in;
   logic                       rd_cur_vld_ff, rd_cur_vld_in;
   logic [NUM_CPUS-1:0]        max_vld_ff, max_vld_in;
   logic [NUM_CPUS-1:0]        cur_vld_ff, cur_vld_in;
   logic [NUM_CPUS-1:0]        boost_ff, boost_in;

   // Memories: one write and one registered read each cycle.
   always_ff @(posedge clock) begin
      if (ctl.wr_max) begin
         max_mem[idx] <= wr_data;
      end
      if (ctl.wr_cur) begin
         cur_mem[idx] <= wr_data;
      end
      rd_max_ff <= max_mem[idx];
      rd_cur_ff <= cur_mem[idx];
   end

   // An entry never written reads as zero.
   assign max_q = rd_max_vld_ff ? rd_max_ff : '0;
   assign cur_q = rd_cur_vld_ff ? rd_cur_ff : '0;

   // Valid and boost bits; a write uses the other table's value read earlier.
   always_comb begin
      max_vld_in    = max_vld_ff;
      cur_vld_in    = cur_vld_ff;
      boost_in      = boost_ff;
      rd_max_vld_in = max_vld_ff[idx];
      rd_cur_vld_in = cur_vld_ff[idx];
      if (ctl.wr_max) begin
         max_vld_in[idx] = 1'b1;
         boost_in[idx]   = (wr_data != '0) && (wr_data == cur_q);
      end
      if (ctl.wr_cur) begin
         cur_vld_in[idx] = 1'b1;
         boost_in[idx]   = (max_q != '0) && (max_q == wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_vld_ff    <= '0;
         cur_vld_ff    <= '0;
         boost_ff      <= '0;
         rd_max_vld_ff <= 1'b0;
         rd_cur_vld_ff <= 1'b0;
      end else begin
         max_vld_ff    <= max_vld_in;
         cur_vld_ff    <= cur_vld_in;
         boost_ff      <= boost_in;
         rd_max_vld_ff <= rd_max_vld_in;
         rd_cur_vld_ff <= rd_cur_vld_in;
      end
   end

   assign boost_any = |boost_ff;

endmodule

// File: src/memory_load_target_rate.sv
// ----------------------------------------------------------------------------
// memory_load_target_rate: memory clock governor with CPU boost tracking.
// Load sample: a multiply, then two 64-step divider passes, by the total and then by the load;
// other samples and unknown commands answer directly, CPU events read and write the table
// before evaluation, or go straight to evaluation beyond the table. One item at a time. Sync reset.
// ----------------------------------------------------------------------------
module memory_load_target_rate #(
   parameter int NUM_CPUS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   mlt_req_if.sink                           req_ch,
   mlt_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mlt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mlt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mlt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_TBL_READ  = 10'b00_0000_0010,
      S_TBL_WRITE = 10'b00_0000_0100,
      S_EVAL      = 10'b00_0000_1000,
      S_MUL       = 10'b00_0001_0000,
      S_DIV_A     = 10'b00_0010_0000,
      S_WAIT_A    = 10'b00_0100_0000,
      S_DIV_B     = 10'b00_1000_0000,
      S_WAIT_B    = 10'b01_0000_0000,
      S_RESP      = 10'b10_0000_0000
   } state_type;

   state_type                        state_ff, state_in;
   logic [mlt_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [mlt_pkg::CPU_W-1:0]        cpu_ff, cpu_in;
   logic [mlt_pkg::WORD_W-1:0]       khz_ff, khz_in;
   logic [mlt_pkg::WORD_W-1:0]       busy_ff, busy_in;
   logic [mlt_pkg::WORD_W-1:0]       total_ff, total_in;
   logic [mlt_pkg::WORD_W-1:0]       mrate_ff, mrate_in;
   logic [mlt_pkg::LOAD_W-1:0]       load_ff, load_in;
   logic [mlt_pkg::RATE_W-1:0]       acc_ff, acc_in;
   logic                             evaluate_ff, evaluate_in;
   logic                             boost_flag_ff, boost_flag_in;
   logic [mlt_pkg::LOAD_W-1:0]       normal_ff, normal_in;
   logic [mlt_pkg::LOAD_W-1:0]       boosted_ff, boosted_in;
   logic [mlt_pkg::RATE_W-1:0]       target_ff, target_in;
   logic                             rate_valid_ff, rate_valid_in;
   logic                             boost_active_ff, boost_active_in;
   logic                             boost_changed_ff, boost_changed_in;

   logic                             req_xfer;
   logic                             csr_write;
   logic                             in_range;
   logic                             big_counts;
   logic [mlt_pkg::WORD_W-1:0]       busy_scaled;
   logic [mlt_pkg::WORD_W-1:0]       total_scaled;
   logic [mlt_pkg::LOAD_W-1:0]       load_sel;
   logic [mlt_pkg::RATE_W-1:0]       product;
   logic [mlt_pkg::RATE_W-1:0]       quo_scaled;

   mlt_pkg::tbl_ctl_type             tbl_ctl;
   logic [mlt_pkg::WORD_W-1:0]       tbl_max_q;
   logic                             boost_any;

   logic                             div_start;
   logic [mlt_pkg::DSR_W-1:0]        div_divisor;
   logic                             div_done;
   logic [mlt_pkg::DVD_W-1:0]        div_quotient;

   // Per-CPU frequency table.
   mlt_cpu_table #(
      .NUM_CPUS (NUM_CPUS),
      .IDX_W    (IDX_W)
   ) u_cpu_table (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tbl_ctl),
      .idx       (IDX_W'(cpu_ff)),
      .wr_data   (khz_ff),
      .max_q     (tbl_max_q),
      .boost_any (boost_any)
   );

   // Shared divider: first by the total count, then by the load percent.
   mlt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign div_divisor = (state_ff == S_DIV_B) ?
                        mlt_pkg::DSR_W'(load_ff) : total_ff;

   // Configuration port: fixed zero wait state, byte offsets 0 and 4.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == mlt_pkg::REG_BOOSTED_LOAD) ?
                       mlt_pkg::CSR_DATA_W'(boosted_ff) : mlt_pkg::CSR_DATA_W'(normal_ff);

   always_comb begin
      normal_in  = normal_ff;
      boosted_in = boosted_ff;
      if (csr_write) begin
         if (csr_paddr[2] == mlt_pkg::REG_BOOSTED_LOAD) begin
            boosted_in = csr_pwdata[mlt_pkg::LOAD_W-1:0];
         end else begin
            normal_in = csr_pwdata[mlt_pkg::LOAD_W-1:0];
         end
      end
   end

   // Request decode helpers.
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign in_range     = 32'(req_ch.cpu_index) < 32'(NUM_CPUS);
   assign big_counts   = (req_ch.busy_count >= mlt_pkg::SHIFT_LIMIT) ||
                         (req_ch.window_total >= mlt_pkg::SHIFT_LIMIT);
   assign busy_scaled  = big_counts ? (req_ch.busy_count >> mlt_pkg::COUNT_SHIFT)
                                    : req_ch.busy_count;
   assign total_scaled = big_counts ? (req_ch.window_total >> mlt_pkg::COUNT_SHIFT)
                                    : req_ch.window_total;
   assign load_sel     = boost_any ? boosted_ff : normal_ff;

   // Arithmetic around the divider: 32x32 product and times 100 as shifts.
   assign product    = 64'(busy_ff) * 64'(mrate_ff);
   assign quo_scaled = (div_quotient << 6) + (div_quotient << 5) + (div_quotient << 2);

   // Sequencer.
   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      cpu_in           = cpu_ff;
      khz_in           = khz_ff;
      busy_in          = busy_ff;
      total_in         = total_ff;
      mrate_in         = mrate_ff;
      load_in          = load_ff;
      acc_in           = acc_ff;
      evaluate_in      = evaluate_ff;
      boost_flag_in    = boost_flag_ff;
      target_in        = target_ff;
      rate_valid_in    = rate_valid_ff;
      boost_active_in  = boost_active_ff;
      boost_changed_in = boost_changed_ff;
      tbl_ctl          = '0;
      div_start        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in           = req_ch.command;
               cpu_in           = req_ch.cpu_index;
               khz_in           = req_ch.cpu_khz;
               target_in        = '0;
               rate_valid_in    = 1'b0;
               boost_active_in  = boost_any;
               boost_changed_in = 1'b0;
               case (req_ch.command)
                  mlt_pkg::CMD_SAMPLE: begin
                     rate_valid_in = 1'b1;
                     if (req_ch.polling_stopped) begin
                        target_in = mlt_pkg::RATE_W'(req_ch.suspend_rate_hz);
                        state_in  = S_RESP;
                     end else if (req_ch.window_total == '0 || total_scaled == '0) begin
                        target_in = '1;
                        state_in  = S_RESP;
                     end else begin
                        busy_in  = busy_scaled;
                        total_in = total_scaled;
                        mrate_in = req_ch.memory_rate_hz;
                        load_in  = (load_sel == '0) ? mlt_pkg::LOAD_W'(1) : load_sel;
                        state_in = S_MUL;
                     end
                  end
                  mlt_pkg::CMD_CPU_MAX, mlt_pkg::CMD_CPU_CUR: begin
                     if (in_range) begin
                        state_in = S_TBL_READ;
                     end else begin
                        evaluate_in = 1'b1;
                        state_in    = S_EVAL;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_TBL_READ: begin
            state_in = S_TBL_WRITE;
         end
         S_TBL_WRITE: begin
            // A maximum equal to the stored one is ignored entirely.
            if (cmd_ff == mlt_pkg::CMD_CPU_MAX && tbl_max_q == khz_ff) begin
               evaluate_in = 1'b0;
            end else begin
               evaluate_in    = 1'b1;
               tbl_ctl.wr_max = (cmd_ff == mlt_pkg::CMD_CPU_MAX);
               tbl_ctl.wr_cur = (cmd_ff == mlt_pkg::CMD_CPU_CUR);
            end
            state_in = S_EVAL;
         end
         S_EVAL: begin
            boost_active_in  = boost_any;
            boost_changed_in = evaluate_ff && (boost_any != boost_flag_ff);
            if (evaluate_ff) begin
               boost_flag_in = boost_any;
            end
            state_in = S_RESP;
         end
         S_MUL: begin
            acc_in   = product;
            state_in = S_DIV_A;
         end
         S_DIV_A: begin
            div_start = 1'b1;
            state_in  = S_WAIT_A;
         end
         S_WAIT_A: begin
            if (div_done) begin
               acc_in   = quo_scaled;
               state_in = S_DIV_B;
            end
         end
         S_DIV_B: begin
            div_start = 1'b1;
            state_in  = S_WAIT_B;
         end
         S_WAIT_B: begin
            if (div_done) begin
               target_in       = div_quotient;
               boost_active_in = boost_any;
               state_in        = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         boost_flag_ff <= 1'b0;
         normal_ff     <= mlt_pkg::NORMAL_LOAD_RESET;
         boosted_ff    <= mlt_pkg::BOOSTED_LOAD_RESET;
      end else begin
         state_ff      <= state_in;
         boost_flag_ff <= boost_flag_in;
         normal_ff     <= normal_in;
         boosted_ff    <= boosted_in;
      end
   end

   // Payload and result registers.
   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      cpu_ff           <= cpu_in;
      khz_ff           <= khz_in;
      busy_ff          <= busy_in;
      total_ff         <= total_in;
      mrate_ff         <= mrate_in;
      load_ff          <= load_in;
      acc_ff           <= acc_in;
      evaluate_ff      <= evaluate_in;
      target_ff        <= target_in;
      rate_valid_ff    <= rate_valid_in;
      boost_active_ff  <= boost_active_in;
      boost_changed_ff <= boost_changed_in;
   end

   // Result channel.
   assign rsp_ch.valid          = (state_ff == S_RESP);
   assign rsp_ch.requested_rate = target_ff;
   assign rsp_ch.rate_valid     = rate_valid_ff;
   assign rsp_ch.boost_active   = boost_active_ff;
   assign rsp_ch.boost_changed  = boost_changed_ff;

endmodule

// File: src/mlt_checker.sv
// ----------------------------------------------------------------------------
// mlt_checker
// Port-level checks for the memory load governor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mlt_pkg::RATE_W-1:0]    rsp_requested_rate,
   input logic                          rsp_rate_valid,
   input logic                          rsp_boost_changed
);

   // A stalled result holds until its transfer.
   `MLT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_requested_rate), "stalled result changed")

   // Only one item is in the block at a time.
   `MLT_ASSERT_NEVER(a_one_item, clock, reset, req_ready && rsp_valid, "request taken while a result waits")

   // A load sample never reports a boost flip.
   `MLT_ASSERT(a_sample_no_flip, clock, reset, rsp_valid && rsp_rate_valid |-> !rsp_boost_changed, "boost change on a load sample")

   // Results of CPU events carry no rate.
   `MLT_ASSERT(a_event_zero_rate, clock, reset, rsp_valid && !rsp_rate_valid |-> rsp_requested_rate == '0, "rate without a load sample")

endmodule

bind memory_load_target_rate mlt_checker u_mlt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_requested_rate (rsp_ch.requested_rate),
   .rsp_rate_valid     (rsp_ch.rate_valid),
   .rsp_boost_changed  (rsp_ch.boost_changed)
);
